>>> src/ira_pkg.sv
// Shared types, constants and helpers for the integer to radix ASCII core.
// Used by ira_ctrl, ira_datapath and integer_to_radix_ascii_core.
`default_nettype none

package ira_pkg;

  localparam int DIV_STEPS = 8;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [6:0] SIGN_CHAR  = 7'h2D;
  localparam logic [6:0] ZERO_CHAR  = 7'h30;
  localparam logic [6:0] UPPER_BASE = 7'h41;
  localparam logic [6:0] LOWER_BASE = 7'h61;
  localparam logic [3:0] TEN        = 4'd10;

  localparam int FLAG_UNSIGNED = 0;
  localparam int FLAG_LOWER    = 1;

  typedef struct packed {
    logic load;
    logic divide;
    logic ptr_dec;
    logic sel_sign;
  } ira_cmd_t;

  typedef struct packed {
    logic finish;
    logic ptr_zero;
    logic negative;
  } ira_status_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic lower);
    logic [6:0] base;
    base = lower ? LOWER_BASE : UPPER_BASE;
    if (d < TEN) begin
      digit_char = ZERO_CHAR + {3'b000, d};
    end else begin
      digit_char = base + {3'b000, d - TEN};
    end
  endfunction

endpackage

`default_nettype wire

>>> src/integer_to_radix_ascii_core.sv
// Integer to radix ASCII converter, top level. Depends on ira_pkg, ira_ctrl, ira_datapath.
// One transaction at a time. After the load, the divider finds each digit in chunks
// of 8 quotient bits per cycle.
// Output: sign character, then each digit as a buffer read followed by a present with ready high.
// rst is synchronous active high and returns the block to idle; the digit buffer is not cleared.
`default_nettype none

module integer_to_radix_ascii_core
  import ira_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value,
  input  wire logic [4:0]  radix,
  input  wire logic [1:0]  format_flags,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       character,
  output logic             last_char
);

  ira_cmd_t    cmd;
  ira_status_t status;

  ira_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ira_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .radix        (radix),
    .format_flags (format_flags),
    .cmd          (cmd),
    .status       (status),
    .character    (character),
    .last_char    (last_char)
  );

endmodule

`default_nettype wire

>>> src/ira_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module ira_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/ira_ctrl.sv
// Sequencing state machine: load, digit division, sign and digit output.
// Depends on ira_pkg for command and status types.
`default_nettype none

module ira_ctrl
  import ira_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire ira_status_t status,
  output ira_cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    SIGN,
    FETCH,
    SHOW
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == SIGN) || (state == SHOW);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.sel_sign = (state == SIGN);
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DIVIDE;
        end
      end
      DIVIDE: begin
        cmd.divide = 1'b1;
        if (status.finish) begin
          state_next = status.negative ? SIGN : FETCH;
        end
      end
      SIGN: begin
        if (out_ready) begin
          state_next = SHOW;
        end
      end
      FETCH: begin
        state_next = SHOW;
      end
      SHOW: begin
        if (out_ready) begin
          if (status.ptr_zero) begin
            state_next = IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next  = FETCH;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/ira_datapath.sv
// Magnitude register, chunked restoring divider, digit buffer and character decode.
// Depends on ira_pkg and ira_ram.
`default_nettype none

module ira_datapath
  import ira_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] value,
  input  wire logic [4:0]  radix,
  input  wire logic [1:0]  format_flags,
  input  wire ira_cmd_t    cmd,
  output ira_status_t      status,
  output logic [6:0]       character,
  output logic             last_char
);

  localparam int W      = VALUE_WIDTH;
  localparam int CHUNKS = (W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DW     = CHUNKS * DIV_STEPS;
  localparam int SW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int AW     = $clog2(W);
  localparam int CW     = $clog2(W + 1);

  logic [DW-1:0] work;
  logic [3:0]    rem;
  logic [4:0]    radix_q;
  logic [SW-1:0] step;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_ptr;
  logic          negative;
  logic          lower;

  logic [W-1:0]  val_w;
  logic [W-1:0]  mag_w;
  logic          neg_in;
  logic [4:0]    radix_sat;

  logic [DW-1:0] quot;
  logic [4:0]    part;
  logic          div_last;
  logic          wr_en;
  logic [3:0]    rd_data;

  assign val_w  = W'(value);
  assign neg_in = !format_flags[FLAG_UNSIGNED] && val_w[W-1];
  assign mag_w  = neg_in ? (~val_w + 1'b1) : val_w;

  always_comb begin
    radix_sat = radix;
    if (radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end
  end

  always_comb begin
    logic [4:0] t;
    part = (step == '0) ? 5'd0 : {1'b0, rem};
    quot = work;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {part[3:0], quot[DW-1]};
      if (t >= radix_q) begin
        part = t - radix_q;
        quot = {quot[DW-2:0], 1'b1};
      end else begin
        part = t;
        quot = {quot[DW-2:0], 1'b0};
      end
    end
  end

  assign div_last = (step == SW'(CHUNKS - 1));
  assign wr_en    = cmd.divide && div_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.load) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.divide) begin
      if (div_last) begin
        step  <= '0;
        count <= count + 1'b1;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work     <= DW'(mag_w);
      radix_q  <= radix_sat;
      negative <= neg_in;
      lower    <= format_flags[FLAG_LOWER];
    end else if (cmd.divide) begin
      work <= quot;
      rem  <= part[3:0];
      if (div_last) begin
        rd_ptr <= count[AW-1:0];
      end
    end else if (cmd.ptr_dec) begin
      rd_ptr <= rd_ptr - 1'b1;
    end
  end

  ira_ram #(
    .WIDTH (4),
    .DEPTH (W)
  ) u_digits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (part[3:0]),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  assign status.finish   = div_last && ((quot == '0) || (count == CW'(W - 1)));
  assign status.ptr_zero = (rd_ptr == '0);
  assign status.negative = negative;

  assign character = cmd.sel_sign ? SIGN_CHAR : digit_char(rd_data, lower);
  assign last_char = !cmd.sel_sign && (rd_ptr == '0);

endmodule

`default_nettype wire

>>> sim/integer_to_radix_ascii_core_tb.sv
// Testbench for integer_to_radix_ascii_core: drives numbers through the valid/ready input
// and checks every emitted character against a built-in predictor of the conversion.
// Depends on ira_pkg and the core RTL.

module integer_to_radix_ascii_core_tb;
  import ira_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 250;

  localparam logic [1:0] FMT_SIGNED_UPPER   = 2'b00;
  localparam logic [1:0] FMT_UNSIGNED_UPPER = 2'b01;
  localparam logic [1:0] FMT_SIGNED_LOWER   = 2'b10;
  localparam logic [1:0] FMT_UNSIGNED_LOWER = 2'b11;

  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value = '0;
  logic [4:0]  radix = 5'd10;
  logic [1:0]  format_flags = FMT_SIGNED_UPPER;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  character;
  logic        last_char;

  text_char_t expected_text[$];
  int mismatch_total = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;

  integer_to_radix_ascii_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .radix(radix),
    .format_flags(format_flags),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last_char(last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_total++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Text of one number, most significant digit first.
  task automatic predict_text(input logic [31:0] num, input logic [4:0] base_in,
                              input logic [1:0] fmt);
    logic [31:0] mag;
    logic [31:0] base;
    logic        neg;
    logic        lower;
    logic [3:0]  digits[$];
    logic [3:0]  d;
    text_char_t  c;
    base = (base_in < RADIX_MIN) ? 32'(RADIX_MIN) :
           (base_in > RADIX_MAX) ? 32'(RADIX_MAX) : 32'(base_in);
    neg = !fmt[FLAG_UNSIGNED] && num[31];
    lower = fmt[FLAG_LOWER];
    mag = neg ? (32'd0 - num) : num;
    do begin
      digits.push_back(4'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (neg) begin
      c.ch = SIGN_CHAR;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    while (digits.size() > 0) begin
      d = digits.pop_back();
      if (d < 4'd10) begin
        c.ch = ASCII_ZERO + 7'(d);
      end else begin
        c.ch = (lower ? ASCII_LOWER_A : ASCII_UPPER_A) + 7'(d - 4'd10);
      end
      c.last = (digits.size() == 0);
      expected_text.push_back(c);
    end
  endtask

  // Leaves in_valid high on return; the caller either sends again or calls idle_input
  // in the same time step.
  task automatic send_number(input logic [31:0] num, input logic [4:0] base,
                             input logic [1:0] fmt);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 300) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= num;
    radix <= base;
    format_flags <= fmt;
    do @(posedge clk); while (!in_ready);
    predict_text(num, base, fmt);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(6))
      0: random_number = r;
      1: random_number = r >> $urandom_range(31);
      2: random_number = $urandom_range(40);
      3: random_number = 32'd0 - $urandom_range(40);
      4: random_number = {1'b1, 31'(r >> $urandom_range(31))};
      5: random_number = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: random_number = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  task automatic test_directed_edges();
    idle_pct = 0;
    stall_pct = 0;
    send_number(32'h0, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'h0, 5'd2, FMT_UNSIGNED_UPPER);
    send_number(32'h0, 5'd16, FMT_UNSIGNED_LOWER);
    send_number(32'h8000_0000, 5'd2, FMT_SIGNED_UPPER);
    send_number(32'h8000_0000, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'h8000_0000, 5'd16, FMT_UNSIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd2, FMT_UNSIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd16, FMT_UNSIGNED_UPPER);
    send_number(32'hFFFF_FFFF, 5'd16, FMT_UNSIGNED_LOWER);
    send_number(32'h7FFF_FFFF, 5'd10, FMT_SIGNED_UPPER);
    send_number(32'hDEAD_BEEF, 5'd16, FMT_UNSIGNED_LOWER);
    send_number(32'hDEAD_BEEF, 5'd16, FMT_SIGNED_UPPER);
    send_number(32'h00AB_CDEF, 5'd16, FMT_SIGNED_LOWER);
    // radix saturation below and above the legal range
    send_number(32'h0000_0055, 5'd0, FMT_UNSIGNED_UPPER);
    send_number(32'h0000_0055, 5'd1, FMT_SIGNED_UPPER);
    send_number(32'h0000_FACE, 5'd17, FMT_SIGNED_LOWER);
    send_number(32'hCAFE_F00D, 5'd31, FMT_UNSIGNED_UPPER);
    send_number(32'h1234_5678, 5'd3, FMT_UNSIGNED_UPPER);
    send_number(32'h8765_4321, 5'd7, FMT_SIGNED_UPPER);
    send_number(32'd123_456_789, 5'd11, FMT_UNSIGNED_LOWER);
    send_number(32'hFFFF_FF85, 5'd13, FMT_SIGNED_LOWER);
    send_number(32'd1, 5'd2, FMT_SIGNED_UPPER);
    send_number(32'd15, 5'd16, FMT_SIGNED_LOWER);
    send_number(32'h0BAD_C0DE, 5'd15, FMT_UNSIGNED_UPPER);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    logic [4:0] base;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      base = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(2, 16));
      send_number(random_number(), base, 2'($urandom_range(3)));
    end
  endtask

  // Receiver holds off long enough that the core stalls on its output with in_ready low.
  task automatic test_output_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 400;
    for (int i = 0; i < 8; i++) begin
      send_number(random_number(), 5'($urandom_range(2, 16)), 2'($urandom_range(3)));
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected character", {1'b0, character}, 8'h00);
      end else begin
        want = expected_text.pop_front();
        if (character !== want.ch) begin
          report_mismatch("character", {1'b0, character}, {1'b0, want.ch});
        end
        if (last_char !== want.last) begin
          report_mismatch("last_char", {7'd0, last_char}, {7'd0, want.last});
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_random_traffic(0, 0, 90);
    test_random_traffic(87, 0, 90);
    test_random_traffic(0, 87, 90);
    test_random_traffic(6, 6, 92);
    test_output_backpressure();
    idle_input();
    stall_pct = 0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_text.size() != 0) begin
      report_mismatch("characters never sent", 8'(expected_text.size()), 8'h00);
    end
    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
